@@ rtl/twcr_pkg.sv @@
// Shared types, constants and codes of the textured wall column renderer.
package twcr_pkg;

  localparam int unsigned SCREEN_HEIGHT_DEF = 64;
  localparam int unsigned TEX_WIDTH_DEF     = 64;
  localparam int unsigned TEX_HEIGHT_DEF    = 64;

  localparam int unsigned NUM_TEX   = 4;
  // dividend covers TEX_HEIGHT << 16 at the largest texture height
  localparam int unsigned DVD_W     = 25;
  localparam int unsigned DVS_W     = 32;
  localparam int unsigned LH_W      = 21;
  localparam int unsigned LH_MAX    = 1 << 20;
  localparam int unsigned HALF_W    = 20;
  localparam int unsigned POS_W     = 26;
  localparam int unsigned ROW_W     = 7;
  localparam int unsigned OQ_DEPTH  = 4;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LH,
    ST_DIV_STEP,
    ST_POS,
    ST_EMIT
  } state_e;

  // classified command word handed from front to back
  typedef struct packed {
    op_e         op;
    logic [9:0]  column;
    logic [31:0] perp;
    logic [19:0] dsel;
    logic [31:0] vsel;
    logic [1:0]  tex_id;
    logic        mirror;
    logic        ld_ok;
    logic [1:0]  ld_id;
    logic [5:0]  ld_row;
    logic [5:0]  ld_col;
    logic [23:0] color;
  } cmd_t;

endpackage

@@ rtl/twcr_ram.sv @@
// Generic single write, single registered read port RAM.
module twcr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/twcr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module twcr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [twcr_pkg::DVD_W-1:0]    dividend_i,
  input  logic [twcr_pkg::DVS_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [twcr_pkg::DVD_W-1:0]    quotient_o
);

  localparam int unsigned CNT_W = $clog2(twcr_pkg::DVD_W);

  logic                        busy_q, done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [twcr_pkg::DVD_W-1:0]  dvd_q;
  logic [twcr_pkg::DVS_W-1:0]  dvs_q, rem_q;
  logic [twcr_pkg::DVS_W:0]    trial, diff;
  logic                        ge;

  always_comb begin
    trial = {rem_q, dvd_q[twcr_pkg::DVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = ge ? (trial - {1'b0, dvs_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(twcr_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[twcr_pkg::DVD_W-2:0], ge};
      rem_q <= diff[twcr_pkg::DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ rtl/twcr_front.sv @@
// Front end: accepts words, classifies them and queues commands for the back end.
module twcr_front #(
  parameter int unsigned TEX_WIDTH  = twcr_pkg::TEX_WIDTH_DEF,
  parameter int unsigned TEX_HEIGHT = twcr_pkg::TEX_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               op_i,
  input  logic [9:0]         column_i,
  input  logic [31:0]        perp_dist_i,
  input  logic               hit_side_i,
  input  logic signed [19:0] ray_dir_x_i,
  input  logic signed [19:0] ray_dir_y_i,
  input  logic [31:0]        view_x_i,
  input  logic [31:0]        view_y_i,
  input  logic [1:0]         load_tex_id_i,
  input  logic [5:0]         load_tex_row_i,
  input  logic [5:0]         load_tex_col_i,
  input  logic [23:0]        load_color_i,
  output logic               cmd_valid_o,
  input  logic               cmd_take_i,
  output twcr_pkg::cmd_t     cmd_o
);

  twcr_pkg::cmd_t cls;
  twcr_pkg::cmd_t q_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           dx_neg, dx_pos, dy_neg, do_push, do_pop;

  always_comb begin
    dx_neg = ray_dir_x_i[19];
    dx_pos = !ray_dir_x_i[19] && (ray_dir_x_i != '0);
    dy_neg = ray_dir_y_i[19];
    cls.op     = twcr_pkg::op_e'(op_i);
    cls.column = column_i;
    cls.perp   = perp_dist_i;
    cls.dsel   = hit_side_i ? ray_dir_x_i : ray_dir_y_i;
    cls.vsel   = hit_side_i ? view_x_i : view_y_i;
    if (hit_side_i) begin
      cls.tex_id = dy_neg ? 2'd0 : 2'd1;
      cls.mirror = dy_neg;
    end else begin
      cls.tex_id = dx_neg ? 2'd2 : 2'd3;
      cls.mirror = dx_pos;
    end
    // loads outside the texture size are dropped
    cls.ld_ok  = (32'(load_tex_row_i) < 32'(TEX_HEIGHT)) &&
                 (32'(load_tex_col_i) < 32'(TEX_WIDTH));
    cls.ld_id  = load_tex_id_i;
    cls.ld_row = load_tex_row_i;
    cls.ld_col = load_tex_col_i;
    cls.color  = load_color_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_q] <= cls;
    end
  end

endmodule

@@ rtl/twcr_back.sv @@
// Back end: texel writes, column setup, pixel stepping and the result queue.
module twcr_back #(
  parameter int unsigned SCREEN_HEIGHT = twcr_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned TEX_WIDTH     = twcr_pkg::TEX_WIDTH_DEF,
  parameter int unsigned TEX_HEIGHT    = twcr_pkg::TEX_HEIGHT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_take_o,
  input  twcr_pkg::cmd_t cmd_i,
  output logic           empty,
  input  logic           pop,
  output logic [5:0]     pixel_row_o,
  output logic [9:0]     pixel_column_o,
  output logic [23:0]    pixel_color_o,
  output logic           last_o
);

  localparam int unsigned TX_W    = $clog2(TEX_WIDTH);
  localparam int unsigned TY_W    = $clog2(TEX_HEIGHT);
  localparam int unsigned DEPTH   = twcr_pkg::NUM_TEX * TEX_WIDTH * TEX_HEIGHT;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned HALF_SH = SCREEN_HEIGHT / 2;
  localparam int unsigned OQ_AW   = $clog2(twcr_pkg::OQ_DEPTH);
  localparam int unsigned OQ_CW   = $clog2(twcr_pkg::OQ_DEPTH + 1);
  localparam int unsigned ROW_W   = twcr_pkg::ROW_W;
  localparam int unsigned HALF_W  = twcr_pkg::HALF_W;

  twcr_pkg::state_e state_q, state_d;
  twcr_pkg::cmd_t   cmd_q;

  logic                        div_start, div_done;
  logic [twcr_pkg::DVD_W-1:0]  div_dvd, div_q;
  logic [twcr_pkg::DVS_W-1:0]  div_dvs;

  logic [31:0]                 prod_q, frac_q;
  logic [TX_W-1:0]             tx_q, txm;
  logic [TY_W-1:0]             ty;
  logic [twcr_pkg::LH_W-1:0]   lh_sat;
  logic [HALF_W-1:0]           half, off_c, off_q;
  logic [HALF_W:0]             end_sum;
  logic [ROW_W-1:0]            start_c, end_c, row_q, end_q;
  logic                        empty_c;
  logic [twcr_pkg::DVD_W-1:0]  step_q;
  logic [twcr_pkg::POS_W-1:0]  pos_q;

  logic                        ram_we, issue, last_iss, inflight_q;
  logic [AW-1:0]               waddr, raddr;
  logic [23:0]                 rdata;
  logic [5:0]                  mrow_q;
  logic [9:0]                  mcol_q;
  logic                        mlast_q;

  logic [5:0]                  oq_row_q   [twcr_pkg::OQ_DEPTH];
  logic [9:0]                  oq_col_q   [twcr_pkg::OQ_DEPTH];
  logic [23:0]                 oq_color_q [twcr_pkg::OQ_DEPTH];
  logic                        oq_last_q  [twcr_pkg::OQ_DEPTH];
  logic [OQ_AW-1:0]            oq_wr_q, oq_rd_q;
  logic [OQ_CW-1:0]            oq_cnt_q;
  logic                        oq_pop;

  twcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  twcr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.color),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // column geometry from the line height quotient
  always_comb begin
    lh_sat  = (div_q > twcr_pkg::DVD_W'(twcr_pkg::LH_MAX)) ?
              twcr_pkg::LH_W'(twcr_pkg::LH_MAX) : div_q[twcr_pkg::LH_W-1:0];
    half    = lh_sat[twcr_pkg::LH_W-1:1];
    end_sum = {1'b0, half} + (HALF_W + 1)'(HALF_SH);
    if (half >= HALF_W'(HALF_SH)) begin
      start_c = '0;
      off_c   = half - HALF_W'(HALF_SH);
    end else begin
      start_c = ROW_W'(HALF_SH) - ROW_W'(half);
      off_c   = '0;
    end
    end_c   = (end_sum >= (HALF_W + 1)'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1) :
              ROW_W'(end_sum);
    empty_c = (lh_sat == '0) || (start_c >= end_c);
  end

  always_comb begin
    ty       = pos_q[16 +: TY_W];
    txm      = cmd_q.mirror ? (TX_W'(TEX_WIDTH - 1) - tx_q) : tx_q;
    raddr    = AW'((AW'(cmd_q.tex_id) * AW'(TEX_HEIGHT) + AW'(ty)) * AW'(TEX_WIDTH)
                   + AW'(txm));
    waddr    = AW'((AW'(cmd_i.ld_id) * AW'(TEX_HEIGHT) + AW'(cmd_i.ld_row))
                   * AW'(TEX_WIDTH) + AW'(cmd_i.ld_col));
    last_iss = (row_q == end_q - 1'b1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      twcr_pkg::ST_IDLE: begin
        if (cmd_valid_i && cmd_i.op == twcr_pkg::OP_RENDER) begin
          state_d = twcr_pkg::ST_DIV_LH;
        end
      end
      twcr_pkg::ST_DIV_LH: begin
        if (div_done) begin
          state_d = empty_c ? twcr_pkg::ST_IDLE : twcr_pkg::ST_DIV_STEP;
        end
      end
      twcr_pkg::ST_DIV_STEP: begin
        if (div_done) begin
          state_d = twcr_pkg::ST_POS;
        end
      end
      twcr_pkg::ST_POS: state_d = twcr_pkg::ST_EMIT;
      twcr_pkg::ST_EMIT: begin
        if (issue && last_iss) begin
          state_d = twcr_pkg::ST_IDLE;
        end
      end
      default: state_d = twcr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_take_o = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    div_dvd    = twcr_pkg::DVD_W'(SCREEN_HEIGHT * 65536);
    div_dvs    = cmd_i.perp;
    issue      = 1'b0;
    case (state_q)
      twcr_pkg::ST_IDLE: begin
        cmd_take_o = cmd_valid_i;
        ram_we     = cmd_valid_i && cmd_i.op == twcr_pkg::OP_LOAD && cmd_i.ld_ok;
        div_start  = cmd_valid_i && cmd_i.op == twcr_pkg::OP_RENDER;
      end
      twcr_pkg::ST_DIV_LH: begin
        div_start = div_done && !empty_c;
        div_dvd   = twcr_pkg::DVD_W'(TEX_HEIGHT * 65536);
        div_dvs   = twcr_pkg::DVS_W'(lh_sat);
      end
      twcr_pkg::ST_EMIT: begin
        issue = (oq_cnt_q + OQ_CW'(inflight_q)) < OQ_CW'(twcr_pkg::OQ_DEPTH);
      end
      default: ;
    endcase
  end

  assign oq_pop = pop && (oq_cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= twcr_pkg::ST_IDLE;
      inflight_q <= 1'b0;
      oq_wr_q    <= '0;
      oq_rd_q    <= '0;
      oq_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      inflight_q <= issue;
      if (inflight_q) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + OQ_CW'(inflight_q) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    // wall hit fraction and texture column, settled during the first division
    prod_q <= 32'(cmd_q.perp * {{12{cmd_q.dsel[19]}}, cmd_q.dsel});
    frac_q <= {cmd_q.vsel[15:0], 16'h0000} + prod_q;
    tx_q   <= TX_W'((64'(frac_q) * 64'(TEX_WIDTH)) >> 32);
    if (cmd_take_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == twcr_pkg::ST_DIV_LH && div_done) begin
      row_q <= start_c;
      end_q <= end_c;
      off_q <= off_c;
    end
    if (state_q == twcr_pkg::ST_DIV_STEP && div_done) begin
      step_q <= div_q;
    end
    if (state_q == twcr_pkg::ST_POS) begin
      pos_q <= twcr_pkg::POS_W'(48'(off_q) * 48'(step_q));
    end
    if (issue) begin
      pos_q   <= pos_q + twcr_pkg::POS_W'(step_q);
      row_q   <= row_q + 1'b1;
      mrow_q  <= row_q[5:0];
      mcol_q  <= cmd_q.column;
      mlast_q <= last_iss;
    end
    if (inflight_q) begin
      oq_row_q[oq_wr_q]   <= mrow_q;
      oq_col_q[oq_wr_q]   <= mcol_q;
      oq_color_q[oq_wr_q] <= rdata;
      oq_last_q[oq_wr_q]  <= mlast_q;
    end
  end

  assign empty          = (oq_cnt_q == '0);
  assign pixel_row_o    = oq_row_q[oq_rd_q];
  assign pixel_column_o = oq_col_q[oq_rd_q];
  assign pixel_color_o  = oq_color_q[oq_rd_q];
  assign last_o         = oq_last_q[oq_rd_q];

  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q |-> (oq_cnt_q < OQ_CW'(twcr_pkg::OQ_DEPTH)))
    else $error("result queue overrun");

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= OQ_CW'(twcr_pkg::OQ_DEPTH))
    else $error("result queue count out of range");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == twcr_pkg::ST_DIV_LH || state_q == twcr_pkg::ST_DIV_STEP))
    else $error("quotient arrived outside a division state");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == twcr_pkg::ST_EMIT) |-> (row_q < end_q))
    else $error("pixel row stepped past wall end");

endmodule

@@ rtl/textured_wall_column_render.sv @@
// Top level of the textured wall column renderer.
// Texel loads (op 0) write one word of the four-texture store, unless the row or column lies
// outside the texture size. A column (op 1) runs through a shared restoring divider at one
// quotient bit per cycle: the back end takes the command, divides for the line height, hands
// the quotient over, divides for the texture row step, hands that over and forms the start
// position, then gives one pixel per cycle while the result queue has room, from start row to
// end row minus one, so a column gives at most SCREEN_HEIGHT - 1 pixels. A column with an
// empty wall ends after the first division and gives no words. The front end classifies
// words into a two-deep command queue, so pushes continue while the back end works; results
// leave through a four-deep queue read with pop. Texels must be loaded before any column
// reads them; the store is not cleared at reset.
module textured_wall_column_render #(
  parameter int unsigned SCREEN_HEIGHT = twcr_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned TEX_WIDTH     = twcr_pkg::TEX_WIDTH_DEF,
  parameter int unsigned TEX_HEIGHT    = twcr_pkg::TEX_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               op_i,
  input  logic [9:0]         column_i,
  input  logic [31:0]        perp_dist_i,
  input  logic               hit_side_i,
  input  logic signed [19:0] ray_dir_x_i,
  input  logic signed [19:0] ray_dir_y_i,
  input  logic [31:0]        view_x_i,
  input  logic [31:0]        view_y_i,
  input  logic [1:0]         load_tex_id_i,
  input  logic [5:0]         load_tex_row_i,
  input  logic [5:0]         load_tex_col_i,
  input  logic [23:0]        load_color_i,
  output logic               empty,
  input  logic               pop,
  output logic [5:0]         pixel_row_o,
  output logic [9:0]         pixel_column_o,
  output logic [23:0]        pixel_color_o,
  output logic               last_o
);

  twcr_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_take;

  // classification and command queue
  twcr_front #(.TEX_WIDTH(TEX_WIDTH), .TEX_HEIGHT(TEX_HEIGHT)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .column_i       (column_i),
    .perp_dist_i    (perp_dist_i),
    .hit_side_i     (hit_side_i),
    .ray_dir_x_i    (ray_dir_x_i),
    .ray_dir_y_i    (ray_dir_y_i),
    .view_x_i       (view_x_i),
    .view_y_i       (view_y_i),
    .load_tex_id_i  (load_tex_id_i),
    .load_tex_row_i (load_tex_row_i),
    .load_tex_col_i (load_tex_col_i),
    .load_color_i   (load_color_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_take_i     (cmd_take),
    .cmd_o          (cmd)
  );

  // divider, texture store and pixel stepping
  twcr_back #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TEX_WIDTH     (TEX_WIDTH),
    .TEX_HEIGHT    (TEX_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_take_o     (cmd_take),
    .cmd_i          (cmd),
    .empty          (empty),
    .pop            (pop),
    .pixel_row_o    (pixel_row_o),
    .pixel_column_o (pixel_column_o),
    .pixel_color_o  (pixel_color_o),
    .last_o         (last_o)
  );

endmodule
